// File: sv/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants for the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int OPCODE_W     = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 5;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_SCAN,
        S_RESP
    } slt_state_t;

endpackage

// File: sv/sorted_list_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_table_unit
// Sorted multiset of signed 32-bit keys held in one RAM, ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries opcode and key: insert, remove
//   one copy, or membership query. Output channel (out_valid/out_stall)
//   returns one beat per input beat: found, status and entry_count.
//   Work is a read-modify-write walk over the key RAM, one entry per cycle
//   (read of the next entry overlaps the write of the shifted one):
//     insert: walks down from the top, moving each larger entry up a slot
//     remove: walks to the top to close the gap
//     query : stops at the first match, or walks to the top when absent
//   Full insert, empty store and unused opcodes go straight to the response.
//   One item is in work at a time; the RAM's single read port sets the pace.
//   A finished result sits in the output register; the next beat is taken
//   while it waits. If out_stall holds, the following item finishes its walk
//   and then waits until the output register frees up.
//   Reset empties the store (count cleared); RAM contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_table_unit #(
    parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [slt_pkg::OPCODE_W-1:0]     opcode,
    input  logic signed [slt_pkg::KEY_W-1:0] key,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             found,
    output logic [slt_pkg::STATUS_W-1:0]     status,
    output logic [slt_pkg::COUNT_OUT_W-1:0]  entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    slt_pkg::slt_state_t state_reg, state_next;

    logic [CW-1:0]                    count_reg, count_next;
    logic                             out_valid_reg, out_valid_next;
    logic [AW-1:0]                    idx_reg, idx_next;
    logic [slt_pkg::OPCODE_W-1:0]     op_reg, op_next;
    logic signed [slt_pkg::KEY_W-1:0] key_reg, key_next;
    logic                             found_reg, found_next;
    logic [slt_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic                             found_out_reg, found_out_next;
    logic [slt_pkg::STATUS_W-1:0]     status_out_reg, status_out_next;
    logic [slt_pkg::COUNT_OUT_W-1:0]  count_out_reg, count_out_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [slt_pkg::KEY_W-1:0] ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [slt_pkg::KEY_W-1:0] ram_rdata;

    logic          in_take;
    logic          out_free;
    logic          d_less;
    logic          hit;
    logic          at_last;
    logic          at_zero;
    logic          is_full;
    logic          is_empty;
    logic [CW-1:0] count_m1;

    slt_ram #(
        .WIDTH(slt_pkg::KEY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_stall = (state_reg != slt_pkg::S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign count_m1 = CW'(count_reg - CW'(1));
    assign is_full  = (count_reg >= CAP_C);
    assign is_empty = (count_reg == '0);
    assign d_less   = ($signed(ram_rdata) < key_reg);
    assign hit      = (ram_rdata == key_reg);
    assign at_last  = (CW'(idx_reg) == count_m1);
    assign at_zero  = (idx_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slt_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    if (opcode == slt_pkg::OP_INSERT)
                    begin
                        state_next = (is_full || is_empty) ? slt_pkg::S_RESP
                                                           : slt_pkg::S_INS;
                    end
                    else if (opcode == slt_pkg::OP_REMOVE
                             || opcode == slt_pkg::OP_QUERY)
                    begin
                        state_next = is_empty ? slt_pkg::S_RESP : slt_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = slt_pkg::S_RESP;
                    end
                end
            end
            slt_pkg::S_INS:
            begin
                if (d_less)
                begin
                    state_next = slt_pkg::S_RESP;
                end
                else if (at_zero)
                begin
                    state_next = slt_pkg::S_INS_LAST;
                end
            end
            slt_pkg::S_INS_LAST:
            begin
                state_next = slt_pkg::S_RESP;
            end
            slt_pkg::S_SCAN:
            begin
                if ((op_reg == slt_pkg::OP_QUERY && hit) || at_last)
                begin
                    state_next = slt_pkg::S_RESP;
                end
            end
            slt_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = slt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = slt_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        found_out_next  = found_out_reg;
        status_out_next = status_out_reg;
        count_out_next  = count_out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = key_reg;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        case (state_reg)
            slt_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    op_next     = opcode;
                    key_next    = key;
                    found_next  = 1'b0;
                    status_next = slt_pkg::ST_DONE;
                    if (opcode == slt_pkg::OP_INSERT)
                    begin
                        if (is_full)
                        begin
                            status_next = slt_pkg::ST_FULL;
                        end
                        else if (is_empty)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            ram_wdata  = key;
                            count_next = CW'(1);
                        end
                        else
                        begin
                            // walk down from the top entry
                            ram_re    = 1'b1;
                            ram_raddr = count_m1[AW-1:0];
                            idx_next  = count_m1[AW-1:0];
                        end
                    end
                    else if (opcode == slt_pkg::OP_REMOVE
                             || opcode == slt_pkg::OP_QUERY)
                    begin
                        if (is_empty)
                        begin
                            if (opcode == slt_pkg::OP_REMOVE)
                            begin
                                status_next = slt_pkg::ST_ABSENT;
                            end
                        end
                        else
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            idx_next  = '0;
                        end
                    end
                end
            end
            slt_pkg::S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(idx_reg + 1'b1);
                if (d_less)
                begin
                    ram_wdata  = key_reg;
                    count_next = CW'(count_reg + CW'(1));
                end
                else
                begin
                    // shift entry up one slot, fetch the one below
                    ram_wdata = ram_rdata;
                    if (!at_zero)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(idx_reg - 1'b1);
                        idx_next  = AW'(idx_reg - 1'b1);
                    end
                end
            end
            slt_pkg::S_INS_LAST:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = key_reg;
                count_next = CW'(count_reg + CW'(1));
            end
            slt_pkg::S_SCAN:
            begin
                if (op_reg == slt_pkg::OP_QUERY)
                begin
                    if (hit)
                    begin
                        found_next = 1'b1;
                    end
                    else if (!at_last)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(idx_reg + 1'b1);
                        idx_next  = AW'(idx_reg + 1'b1);
                    end
                end
                else
                begin
                    // once the match is seen, every later entry moves down
                    if (found_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(idx_reg - 1'b1);
                        ram_wdata = ram_rdata;
                    end
                    if (hit)
                    begin
                        found_next = 1'b1;
                    end
                    if (at_last)
                    begin
                        if (found_reg || hit)
                        begin
                            count_next = count_m1;
                        end
                        else
                        begin
                            status_next = slt_pkg::ST_ABSENT;
                        end
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(idx_reg + 1'b1);
                        idx_next  = AW'(idx_reg + 1'b1);
                    end
                end
            end
            slt_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    found_out_next  = found_reg;
                    status_out_next = status_reg;
                    count_out_next  = slt_pkg::COUNT_OUT_W'(count_reg);
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slt_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        found_out_reg  <= found_out_next;
        status_out_reg <= status_out_next;
        count_out_reg  <= count_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_out_reg;
    assign status      = status_out_reg;
    assign entry_count = count_out_reg;

endmodule

// File: sv/slt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module slt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
